FILE: hw/rtl/lfsc_pkg.sv
// Shared types and constants for the line follow steering controller.
// No dependencies; the files that use it refer to it by scoped names.
package lfsc_pkg;

    // Geometry of the scan line
    localparam int ROW_PIXELS = 32;
    localparam logic [6:0] ROW_LIMIT  = 7'(ROW_PIXELS);
    localparam logic [5:0] WHITE_FULL = (ROW_PIXELS > 63) ? 6'd63 : 6'(ROW_PIXELS);

    // Frame summary queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Item opcodes
    localparam logic [1:0] OP_ROW   = 2'd0;
    localparam logic [1:0] OP_LEFT  = 2'd1;
    localparam logic [1:0] OP_RIGHT = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_COUNT_MIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SPEED      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_SPEED      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_DIVISOR    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_LIMIT   = 3'd5;

    // Result actions
    localparam logic [2:0] ACT_STEER       = 3'd0;
    localparam logic [2:0] ACT_REVERSE     = 3'd1;
    localparam logic [2:0] ACT_SHARP_LEFT  = 3'd2;
    localparam logic [2:0] ACT_SHARP_RIGHT = 3'd3;
    localparam logic [2:0] ACT_TURN_AROUND = 3'd4;
    localparam logic [2:0] ACT_MODE_SWITCH = 3'd5;

    // Special line errors and fixed drive values
    localparam logic signed [10:0] ERR_LOST      = 11'sd999;
    localparam logic signed [10:0] ERR_ALL_WHITE = 11'sd666;
    localparam logic signed [12:0] CENTER_HALVES = 13'sd165;
    localparam logic signed [8:0]  DRIVE_REVERSE = -9'sd200;
    localparam logic signed [8:0]  DRIVE_SHARP   = 9'sd180;
    localparam logic signed [8:0]  DRIVE_TURN    = 9'sd190;
    localparam logic signed [8:0]  DRIVE_ZERO    = 9'sd0;

    // Quotient steps of the steering divider
    localparam logic [3:0] DIV_LAST_STEP = 4'd10;

    typedef struct packed {
        logic [7:0] white_threshold;
        logic [4:0] side_count_min;
        logic [7:0] base_speed;
        logic [7:0] fast_speed;
        logic [9:0] gain_divisor;
        logic [3:0] reverse_limit;
    } t_cfg;

    // One finished frame, as handed from front to back
    typedef struct packed {
        logic signed [10:0] err;
        logic               left_branch;
        logic               right_branch;
    } t_summary;

endpackage

FILE: hw/rtl/lfsc_if.sv
// Handshake channels of the line follow steering controller.
// No dependencies.
interface lfsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] pixel;
    logic [4:0] row_index;
    logic       frame_end;
    modport source(output valid, op, pixel, row_index, frame_end, input ready);
    modport sink(input valid, op, pixel, row_index, frame_end, output ready);
endinterface

interface lfsc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [10:0] line_error;
    logic signed [8:0]  motor_one;
    logic signed [8:0]  motor_two;
    modport source(output valid, action, line_error, motor_one, motor_two, input ready);
    modport sink(input valid, action, line_error, motor_one, motor_two, output ready);
endinterface

interface lfsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/line_follow_steering_controller.sv
// Line follow steering controller, top level: configuration registers, front
// end, summary queue and back end. Depends on lfsc_pkg, lfsc_if and submodules.
//
// Pixel items are taken one per cycle while the two-entry frame summary queue
// has room; the item marked frame_end yields one result. A frame that ends in
// reverse, sharp turn, turn around, mode switch or a centered steer appears on
// the output once its summary has passed the queue and the back end's result
// register; off-center steers first run the back end's 11-step serial divider. The
// back end handles one frame at a time, so back-to-back short frames fill the
// queue and stall input until the divider drains it. Configuration writes are
// always accepted and should only be issued while no frame is in flight.
module line_follow_steering_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfsc_in_if.sink     i_pix,
    lfsc_out_if.source  o_res,
    lfsc_cfg_if.sink    i_cfg
);

    lfsc_pkg::t_cfg     r_cfg;
    logic               push_valid, push_ready;
    lfsc_pkg::t_summary push_data;
    logic               pop_valid, pop_ready;
    lfsc_pkg::t_summary pop_data;

    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_threshold <= 8'd100;
            r_cfg.side_count_min  <= 5'd3;
            r_cfg.base_speed      <= 8'd150;
            r_cfg.fast_speed      <= 8'd220;
            r_cfg.gain_divisor    <= 10'd800;
            r_cfg.reverse_limit   <= 4'd9;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lfsc_pkg::CFG_WHITE_THRESHOLD: r_cfg.white_threshold <= i_cfg.data[7:0];
                lfsc_pkg::CFG_SIDE_COUNT_MIN:  r_cfg.side_count_min  <= i_cfg.data[4:0];
                lfsc_pkg::CFG_BASE_SPEED:      r_cfg.base_speed      <= i_cfg.data[7:0];
                lfsc_pkg::CFG_FAST_SPEED:      r_cfg.fast_speed      <= i_cfg.data[7:0];
                lfsc_pkg::CFG_GAIN_DIVISOR:    r_cfg.gain_divisor    <= i_cfg.data[9:0];
                lfsc_pkg::CFG_REVERSE_LIMIT:   r_cfg.reverse_limit   <= i_cfg.data[3:0];
                default: begin
                end
            endcase
        end
    end

    lfsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pix        (i_pix),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    lfsc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    lfsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_res       (o_res)
    );

endmodule

FILE: hw/rtl/lfsc_front.sv
// Front end: accepts pixel items, keeps per-frame tallies and the weighted sum,
// and pushes one frame summary per frame end. Depends on lfsc_pkg, lfsc_if.
module lfsc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfsc_pkg::t_cfg      i_cfg,
    lfsc_in_if.sink             i_pix,
    output logic                o_push_valid,
    output lfsc_pkg::t_summary  o_push_data,
    input  logic                i_push_ready
);

    logic signed [11:0] r_sum, n_sum;
    logic [5:0]         r_white, n_white;
    logic [4:0]         r_left, n_left;
    logic [4:0]         r_right, n_right;

    logic               accept;
    logic               row_ok;
    logic signed [12:0] weight;
    logic signed [12:0] sum_wide;
    logic [11:0]        sum_round;

    // Stall everything while the queue is full
    assign i_pix.ready = i_push_ready;
    assign accept      = i_pix.valid && i_pix.ready;

    assign row_ok = ({2'b00, i_pix.row_index} < lfsc_pkg::ROW_LIMIT);

    // Weight 10*i - 165 in half units, then saturating accumulate
    assign weight   = $signed(13'({i_pix.row_index, 3'b000}) + 13'({i_pix.row_index, 1'b0}))
                      - lfsc_pkg::CENTER_HALVES;
    assign sum_wide = $signed({r_sum[11], r_sum}) + weight;

    // Next tallies including the current item
    always_comb begin
        n_sum   = r_sum;
        n_white = r_white;
        n_left  = r_left;
        n_right = r_right;
        case (i_pix.op)
            lfsc_pkg::OP_ROW: begin
                if (row_ok && (i_pix.pixel >= i_cfg.white_threshold)) begin
                    if (sum_wide > 13'sd2047) begin
                        n_sum = 12'sd2047;
                    end else if (sum_wide < -13'sd2048) begin
                        n_sum = -12'sd2048;
                    end else begin
                        n_sum = sum_wide[11:0];
                    end
                    if (r_white != 6'd63) n_white = r_white + 6'd1;
                end
            end
            lfsc_pkg::OP_LEFT: begin
                if ((i_pix.pixel > i_cfg.white_threshold) && (r_left != 5'd31))
                    n_left = r_left + 5'd1;
            end
            lfsc_pkg::OP_RIGHT: begin
                if ((i_pix.pixel > i_cfg.white_threshold) && (r_right != 5'd31))
                    n_right = r_right + 5'd1;
            end
            default: begin
            end
        endcase
    end

    // Halve toward zero: add one to negative sums before the shift
    assign sum_round = n_sum + {11'd0, n_sum[11]};

    // Frame summary
    always_comb begin
        if (n_white == 6'd0) begin
            o_push_data.err = lfsc_pkg::ERR_LOST;
        end else if (n_white >= lfsc_pkg::WHITE_FULL) begin
            o_push_data.err = lfsc_pkg::ERR_ALL_WHITE;
        end else begin
            o_push_data.err = $signed(sum_round[11:1]);
        end
        o_push_data.left_branch  = n_left > i_cfg.side_count_min;
        o_push_data.right_branch = n_right > i_cfg.side_count_min;
    end

    assign o_push_valid = accept && i_pix.frame_end;

    // Tally registers, cleared after each frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_white <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (accept) begin
            if (i_pix.frame_end) begin
                r_sum   <= '0;
                r_white <= '0;
                r_left  <= '0;
                r_right <= '0;
            end else begin
                r_sum   <= n_sum;
                r_white <= n_white;
                r_left  <= n_left;
                r_right <= n_right;
            end
        end
    end

endmodule

FILE: hw/rtl/lfsc_queue.sv
// Small register queue of frame summaries between front and back.
// Depends on lfsc_pkg.
module lfsc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    input  lfsc_pkg::t_summary  i_push_data,
    output logic                o_push_ready,
    output logic                o_pop_valid,
    output lfsc_pkg::t_summary  o_pop_data,
    input  logic                i_pop_ready
);

    lfsc_pkg::t_summary r_data [lfsc_pkg::QUEUE_DEPTH];
    logic [lfsc_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [lfsc_pkg::QUEUE_CNT_W-1:0] r_count;
    logic push, pop;

    assign o_push_ready = (r_count != lfsc_pkg::QUEUE_CNT_W'(lfsc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_data[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) r_data[r_wr_ptr] <= i_push_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == lfsc_pkg::QUEUE_PTR_W'(lfsc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == lfsc_pkg::QUEUE_PTR_W'(lfsc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/lfsc_back.sv
// Back end: takes frame summaries, runs the mode and reverse decision, divides
// the steering error serially and holds the result. Depends on lfsc_pkg, lfsc_if.
module lfsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfsc_pkg::t_cfg      i_cfg,
    input  logic                i_pop_valid,
    input  lfsc_pkg::t_summary  i_pop_data,
    output logic                o_pop_ready,
    lfsc_out_if.source          o_res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic               r_state, n_state;
    logic               r_mode, n_mode;
    logic [3:0]         r_rev, n_rev;
    logic [3:0]         r_cnt, n_cnt;
    logic [9:0]         r_rem, n_rem;
    logic [10:0]        r_quo, n_quo;
    logic               r_neg, n_neg;
    logic signed [10:0] r_err, n_err;

    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_action, n_out_action;
    logic signed [10:0] r_out_err, n_out_err;
    logic signed [8:0]  r_out_m1, n_out_m1;
    logic signed [8:0]  r_out_m2, n_out_m2;

    logic               out_free;
    logic               pop;
    logic               is_lost, is_white;
    logic [10:0]        mag;
    logic [9:0]         divisor;
    logic [10:0]        trial;
    logic               fits;
    logic [10:0]        quo_step;
    logic [11:0]        slow_sum;
    logic signed [8:0]  slow_drive;
    logic signed [8:0]  fast_drive;
    logic signed [8:0]  base_drive;

    assign out_free    = !r_out_valid || o_res.ready;
    assign o_pop_ready = (r_state == ST_IDLE) && out_free;
    assign pop         = i_pop_valid && o_pop_ready;

    assign is_lost  = (i_pop_data.err == lfsc_pkg::ERR_LOST);
    assign is_white = (i_pop_data.err == lfsc_pkg::ERR_ALL_WHITE);
    assign mag      = i_pop_data.err[10] ? (~i_pop_data.err + 11'd1) : i_pop_data.err;
    assign divisor  = (i_cfg.gain_divisor == 10'd0) ? 10'd1 : i_cfg.gain_divisor;

    // One restoring division step per cycle
    assign trial    = {r_rem, r_quo[10]};
    assign fits     = trial >= {1'b0, divisor};
    assign quo_step = {r_quo[9:0], fits};

    // Slow wheel speed from the final quotient, saturated
    assign slow_sum   = {4'd0, i_cfg.base_speed} + {1'b0, quo_step};
    assign slow_drive = (slow_sum > 12'd255) ? 9'sd255 : $signed({1'b0, slow_sum[7:0]});
    assign fast_drive = $signed({1'b0, i_cfg.fast_speed});
    assign base_drive = $signed({1'b0, i_cfg.base_speed});

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_rev        = r_rev;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_neg        = r_neg;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_action = r_out_action;
        n_out_err    = r_out_err;
        n_out_m1     = r_out_m1;
        n_out_m2     = r_out_m2;

        case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    n_out_err    = i_pop_data.err;
                    n_out_action = lfsc_pkg::ACT_STEER;
                    n_out_m1     = base_drive;
                    n_out_m2     = base_drive;
                    n_out_valid  = 1'b1;
                    if (!r_mode && is_lost) begin
                        n_out_action = lfsc_pkg::ACT_REVERSE;
                        n_out_m1     = lfsc_pkg::DRIVE_REVERSE;
                        n_out_m2     = lfsc_pkg::DRIVE_REVERSE;
                    end else if (!r_mode && is_white) begin
                        n_out_action = lfsc_pkg::ACT_MODE_SWITCH;
                        n_out_m1     = lfsc_pkg::DRIVE_ZERO;
                        n_out_m2     = lfsc_pkg::DRIVE_ZERO;
                        n_mode       = 1'b1;
                    end else if (r_mode && is_lost) begin
                        // Second mode: branches first, then turn around or reverse
                        if (i_pop_data.right_branch) begin
                            n_out_action = lfsc_pkg::ACT_SHARP_LEFT;
                            n_out_m1     = lfsc_pkg::DRIVE_SHARP;
                            n_out_m2     = -lfsc_pkg::DRIVE_SHARP;
                        end else if (i_pop_data.left_branch) begin
                            n_out_action = lfsc_pkg::ACT_SHARP_RIGHT;
                            n_out_m1     = -lfsc_pkg::DRIVE_SHARP;
                            n_out_m2     = lfsc_pkg::DRIVE_SHARP;
                        end else if (r_rev > i_cfg.reverse_limit) begin
                            n_out_action = lfsc_pkg::ACT_TURN_AROUND;
                            n_out_m1     = lfsc_pkg::DRIVE_TURN;
                            n_out_m2     = -lfsc_pkg::DRIVE_TURN;
                            n_rev        = 4'd0;
                        end else begin
                            n_out_action = lfsc_pkg::ACT_REVERSE;
                            n_out_m1     = lfsc_pkg::DRIVE_REVERSE;
                            n_out_m2     = lfsc_pkg::DRIVE_REVERSE;
                            if (r_rev != 4'd15) n_rev = r_rev + 4'd1;
                        end
                    end else if (i_pop_data.err != 11'sd0) begin
                        // Off center: divide the magnitude before answering
                        n_out_valid = 1'b0;
                        n_state     = ST_DIV;
                        n_cnt       = lfsc_pkg::DIV_LAST_STEP;
                        n_rem       = 10'd0;
                        n_quo       = mag;
                        n_neg       = i_pop_data.err[10];
                        n_err       = i_pop_data.err;
                    end
                end
            end
            ST_DIV: begin
                n_rem = fits ? 10'(trial - {1'b0, divisor}) : trial[9:0];
                n_quo = quo_step;
                if (r_cnt == 4'd0) begin
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_action = lfsc_pkg::ACT_STEER;
                    n_out_err    = r_err;
                    if (r_neg) begin
                        n_out_m1 = fast_drive;
                        n_out_m2 = slow_drive;
                    end else begin
                        n_out_m1 = slow_drive;
                        n_out_m2 = fast_drive;
                    end
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 1'b0;
            r_rev       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_rev       <= n_rev;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and result payload
    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_neg        <= n_neg;
        r_err        <= n_err;
        r_out_action <= n_out_action;
        r_out_err    <= n_out_err;
        r_out_m1     <= n_out_m1;
        r_out_m2     <= n_out_m2;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.action     = r_out_action;
    assign o_res.line_error = r_out_err;
    assign o_res.motor_one  = r_out_m1;
    assign o_res.motor_two  = r_out_m2;

endmodule
